// ===== hdl/stma_pkg.sv =====
// Package for the saturation/tone/mix audio core: widths, fixed-point constants,
// sequencer codes, controller/datapath command types and the lookup tables.
// No dependencies.
package stma_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int INTERNAL_BITS = 32;
  localparam int CFG_BITS      = 17;
  localparam int IDX_BITS      = 2;
  localparam int MUL_W         = 36;
  localparam int MUL_CHUNK     = 18;
  localparam int PROD_W        = 2 * MUL_W;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_DRIVE  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_TONE   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MIX    = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_BYPASS = 2'd3;

  localparam logic [CFG_BITS-1:0] UNITY    = 17'd65536;
  localparam logic [CFG_BITS-1:0] TONE_RST = 17'd32768;

  // Q4.27 constants
  localparam logic [31:0] ONE_Q  = 32'd134217728;
  localparam logic [31:0] HALF_Q = 32'd67108864;
  localparam logic [31:0] THR_Q  = 32'd40265318;   // 0.3
  localparam logic [31:0] LIM_Q  = 32'd127506841;  // 0.95
  localparam logic signed [SAMPLE_BITS-1:0] LIM_OUT = 24'sd7969177;

  localparam logic [31:0] GOLD_Q32 = 32'h9E3779B9;  // 0.618034 in Q0.32
  localparam logic [31:0] RECIP10  = 32'hCCCCCCCD;  // 2^35/10, also 2^36/20
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // sequencer codes: op steps plus idle, branch and output states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] OP_DD   = 5'd1;
  localparam logic [4:0] OP_D3   = 5'd2;
  localparam logic [4:0] OP_H    = 5'd3;
  localparam logic [4:0] OP_T7   = 5'd4;
  localparam logic [4:0] OP_S    = 5'd5;
  localparam logic [4:0] OP_A2   = 5'd6;
  localparam logic [4:0] OP_DENS = 5'd7;
  localparam logic [4:0] ST_BR   = 5'd8;
  localparam logic [4:0] OP_U    = 5'd9;
  localparam logic [4:0] OP_V    = 5'd10;
  localparam logic [4:0] OP_EI   = 5'd11;
  localparam logic [4:0] OP_PH   = 5'd12;
  localparam logic [4:0] OP_SI   = 5'd13;
  localparam logic [4:0] OP_H20  = 5'd14;
  localparam logic [4:0] OP_F1   = 5'd15;
  localparam logic [4:0] OP_F2   = 5'd16;
  localparam logic [4:0] OP_MX   = 5'd17;
  localparam logic [4:0] OP_HG   = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       wb;
    logic       emit;
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic byp;
    logic half;
    logic thr;
  } stat_t;

  // 2^(-k/16), Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd65536;
      5'd1:  r = 17'd62757;
      5'd2:  r = 17'd60097;
      5'd3:  r = 17'd57549;
      5'd4:  r = 17'd55109;
      5'd5:  r = 17'd52773;
      5'd6:  r = 17'd50535;
      5'd7:  r = 17'd48393;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd44376;
      5'd10: r = 17'd42495;
      5'd11: r = 17'd40693;
      5'd12: r = 17'd38968;
      5'd13: r = 17'd37316;
      5'd14: r = 17'd35734;
      5'd15: r = 17'd34219;
      5'd16: r = 17'd32768;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // quarter-wave sine, Q16
  function automatic logic [16:0] sin_tab(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd0;
      5'd1:  r = 17'd6424;
      5'd2:  r = 17'd12785;
      5'd3:  r = 17'd19024;
      5'd4:  r = 17'd25080;
      5'd5:  r = 17'd30893;
      5'd6:  r = 17'd36410;
      5'd7:  r = 17'd41576;
      5'd8:  r = 17'd46341;
      5'd9:  r = 17'd50660;
      5'd10: r = 17'd54491;
      5'd11: r = 17'd57798;
      5'd12: r = 17'd60547;
      5'd13: r = 17'd62714;
      5'd14: r = 17'd64277;
      5'd15: r = 17'd65220;
      5'd16: r = 17'd65536;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // symmetric saturation to +/-(2^31-1)
  function automatic logic signed [31:0] sat_q(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sd2147483647;
    else if (v < -36'sd2147483647) r = -32'sd2147483647;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/stma_if.sv =====
// Channel interfaces of the audio core: sample in, sample out, register write.
// Depends on stma_pkg.
interface stma_in_if;
  logic valid;
  logic ready;
  logic signed [stma_pkg::SAMPLE_BITS-1:0] sample_in;
  modport source(output valid, sample_in, input ready);
  modport sink(input valid, sample_in, output ready);
endinterface

interface stma_out_if;
  logic valid;
  logic ready;
  logic signed [stma_pkg::SAMPLE_BITS-1:0] sample_out;
  logic limited;
  modport source(output valid, sample_out, limited, input ready);
  modport sink(input valid, sample_out, limited, output ready);
endinterface

interface stma_cfg_if;
  logic valid;
  logic ready;
  logic [stma_pkg::IDX_BITS-1:0] index;
  logic [stma_pkg::CFG_BITS-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/saturation_tone_mix_audio_core.sv =====
// One shared 36x18 multiplier computes a chain of 11 products when no saturation
//   or harmonic term applies, up to 17 with both; bypass skips the chain.
// Inputs are taken only while idle; the next is taken while the result waits.
// Reset (rst, synchronous): registers to defaults, tone filters cleared, idle.
module saturation_tone_mix_audio_core (
  input logic       clk,
  input logic       rst,
  stma_in_if.sink   in_ch,
  stma_out_if.source out_ch,
  stma_cfg_if.sink  cfg
);
  stma_pkg::cmd_t  cmd;
  stma_pkg::stat_t st;

  assign cfg.ready = 1'b1;

  stma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  stma_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .sample_in  (in_ch.sample_in),
    .sample_out (out_ch.sample_out),
    .limited    (out_ch.limited),
    .cmd        (cmd),
    .st         (st)
  );
endmodule

// ===== hdl/stma_mul.sv =====
// Shared unsigned multiplier: 36x36 product formed as two 36x18 partial
// products accumulated in turn. Depends on stma_pkg.
module stma_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [stma_pkg::MUL_W-1:0]    a_op,
  input  logic [stma_pkg::MUL_W-1:0]    b_op,
  output logic [stma_pkg::PROD_W-1:0]   prod,
  output logic                          done
);
  logic [stma_pkg::MUL_W-1:0] a_r, b_r;
  logic run, cnt;
  logic [stma_pkg::MUL_W+stma_pkg::MUL_CHUNK-1:0] part;
  logic [stma_pkg::PROD_W-1:0] part_sh;

  assign part = a_r * (cnt ? b_r[stma_pkg::MUL_W-1:stma_pkg::MUL_CHUNK]
                           : b_r[stma_pkg::MUL_CHUNK-1:0]);
  assign part_sh = cnt ? {part, {stma_pkg::MUL_CHUNK{1'b0}}}
                       : {{stma_pkg::MUL_CHUNK{1'b0}}, part};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 1'b0;
      end else if (run) begin
        if (cnt) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= ~cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a_op;
      b_r  <= b_op;
      prod <= '0;
    end else if (run) begin
      prod <= prod + part_sh;
    end
  end
endmodule

// ===== hdl/stma_ctrl.sv =====
// Sequencer of the audio core: steps the datapath through its multiply chain
// and owns the input/output handshakes. Depends on stma_pkg.
module stma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output stma_pkg::cmd_t  cmd,
  input  stma_pkg::stat_t st
);
  logic [4:0] state, state_next;
  logic busy, is_op, accept;

  assign in_ready = (state == stma_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign is_op    = (state != stma_pkg::ST_IDLE) && (state != stma_pkg::ST_BR) &&
                    (state != stma_pkg::ST_OUT);

  assign cmd.load  = accept;
  assign cmd.start = is_op & ~busy;
  assign cmd.wb    = is_op & st.done;
  assign cmd.emit  = (state == stma_pkg::ST_OUT) & (~out_valid | out_ready);
  assign cmd.op    = state;

  always_comb begin
    state_next = state;
    case (state)
      stma_pkg::ST_IDLE: if (accept) begin
        state_next = st.byp ? stma_pkg::ST_OUT : stma_pkg::OP_DD;
      end
      stma_pkg::OP_DD:   if (st.done) state_next = stma_pkg::OP_D3;
      stma_pkg::OP_D3:   if (st.done) state_next = stma_pkg::OP_H;
      stma_pkg::OP_H:    if (st.done) state_next = stma_pkg::OP_T7;
      stma_pkg::OP_T7:   if (st.done) state_next = stma_pkg::OP_S;
      stma_pkg::OP_S:    if (st.done) state_next = stma_pkg::OP_A2;
      stma_pkg::OP_A2:   if (st.done) state_next = stma_pkg::OP_DENS;
      stma_pkg::OP_DENS: if (st.done) state_next = stma_pkg::ST_BR;
      stma_pkg::ST_BR: begin
        if (st.half) state_next = stma_pkg::OP_U;
        else if (st.thr) state_next = stma_pkg::OP_PH;
        else state_next = stma_pkg::OP_F1;
      end
      stma_pkg::OP_U:    if (st.done) state_next = stma_pkg::OP_V;
      stma_pkg::OP_V:    if (st.done) state_next = stma_pkg::OP_EI;
      // soft-saturation range always lies inside the harmonic range
      stma_pkg::OP_EI:   if (st.done) state_next = stma_pkg::OP_PH;
      stma_pkg::OP_PH:   if (st.done) state_next = stma_pkg::OP_SI;
      stma_pkg::OP_SI:   if (st.done) state_next = stma_pkg::OP_H20;
      stma_pkg::OP_H20:  if (st.done) state_next = stma_pkg::OP_F1;
      stma_pkg::OP_F1:   if (st.done) state_next = stma_pkg::OP_F2;
      stma_pkg::OP_F2:   if (st.done) state_next = stma_pkg::OP_MX;
      stma_pkg::OP_MX:   if (st.done) state_next = stma_pkg::OP_HG;
      stma_pkg::OP_HG:   if (st.done) state_next = stma_pkg::ST_OUT;
      stma_pkg::ST_OUT:  if (cmd.emit) state_next = stma_pkg::ST_IDLE;
      default:           state_next = stma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stma_pkg::ST_IDLE;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) busy <= 1'b1;
      else if (st.done) busy <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// ===== hdl/stma_dp.sv =====
// Datapath of the audio core: config registers, working registers, tone filter
// state, operand selection for the shared multiplier and the output register.
// Depends on stma_pkg and stma_mul.
module stma_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [stma_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [stma_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic signed [stma_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic signed [stma_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                  limited,
  input  stma_pkg::cmd_t                        cmd,
  output stma_pkg::stat_t                       st
);
  logic [16:0] drive, tone, mix;
  logic        bypass;
  logic [16:0] d, tn, c;

  logic signed [23:0] x;
  logic        byp_item;
  logic [31:0] t1, a, dens;
  logic [16:0] d3, hx, t7;
  logic [35:0] u, v;
  logic signed [31:0] w, ht, st1, st2, o;
  logic [26:0] q;
  logic        hneg;
  logic [27:0] sinv;

  logic [35:0] a_op, b_op, prod_sh;
  logic [71:0] prod;
  logic [6:0]  shamt;
  logic        mul_done;
  logic signed [35:0] prod_s;

  assign d  = (drive > stma_pkg::UNITY) ? stma_pkg::UNITY : drive;
  assign tn = (tone  > stma_pkg::UNITY) ? stma_pkg::UNITY : tone;
  assign c  = (mix   > stma_pkg::UNITY) ? stma_pkg::UNITY : mix;

  logic [18:0] g;
  logic [17:0] h;
  logic [19:0] tn7;
  assign g   = 19'(stma_pkg::UNITY) + {d3, 2'b00};
  assign h   = 18'(stma_pkg::UNITY) + 18'(hx);
  assign tn7 = {tn, 3'b000} - 20'(tn);

  logic        xneg, sneg, spos;
  logic [23:0] xmag;
  logic signed [31:0] s_val;
  assign xneg  = x[23];
  assign xmag  = xneg ? 24'(-x) : 24'(x);
  assign sneg  = xneg & (a != 32'd0);
  assign spos  = ~xneg & (a != 32'd0);
  assign s_val = sneg ? -$signed(a) : $signed(a);

  // exp(-u) = 2^-v, v in Q.27: table on the top 4 fraction bits
  logic [3:0]  eidx;
  logic [22:0] erem, ediff;
  logic [16:0] etab0, etab1, edlt;
  logic [27:0] ebase, eval, e_val, k;
  assign eidx  = v[26:23];
  assign erem  = v[22:0];
  assign etab0 = stma_pkg::exp2_tab({1'b0, eidx});
  assign etab1 = stma_pkg::exp2_tab({1'b0, eidx} + 5'd1);
  assign edlt  = etab0 - etab1;
  assign ediff = {edlt[11:0], 11'b0};
  assign ebase = {etab0, 11'b0};
  assign eval  = ebase - prod_sh[27:0];
  assign e_val = (v[35:33] != 3'd0) ? 28'd0 : (eval >> v[32:27]);
  assign k     = stma_pkg::ONE_Q[27:0] - e_val;

  // sin(pi*q), q in [0, 0.5]
  logic [4:0]  sidx;
  logic [21:0] srem;
  logic [16:0] stab0, stab1, sdlt;
  logic [23:0] sdiff;
  logic [27:0] sbase;
  assign sidx  = q[26:22];
  assign srem  = q[21:0];
  assign stab0 = stma_pkg::sin_tab(sidx);
  assign stab1 = stma_pkg::sin_tab(sidx + 5'd1);
  assign sdlt  = stab1 - stab0;
  assign sdiff = {sdlt[12:0], 11'b0};
  assign sbase = {stab0, 11'b0};

  // phase reduction
  logic [27:0] ph, ph_fold;
  assign ph      = prod_sh[27:0];
  assign ph_fold = stma_pkg::ONE_Q[27:0] - {1'b0, ph[26:0]};

  logic signed [31:0] p;
  logic signed [35:0] dif1, dif2, dif3;
  logic [35:0] mag1, mag2, mag3, omag;
  assign p    = stma_pkg::sat_q(36'(w) + 36'(ht));
  assign dif1 = 36'(p) - 36'(st1);
  assign dif2 = 36'(st1) - 36'(st2);
  assign dif3 = 36'(st2) - 36'(s_val);
  assign mag1 = dif1[35] ? 36'(-dif1) : 36'(dif1);
  assign mag2 = dif2[35] ? 36'(-dif2) : 36'(dif2);
  assign mag3 = dif3[35] ? 36'(-dif3) : 36'(dif3);
  assign omag = o[31] ? 36'(-36'(o)) : 36'(o);
  assign prod_s = $signed(prod_sh);

  always_comb begin
    a_op  = '0;
    b_op  = '0;
    shamt = 7'd16;
    case (cmd.op)
      stma_pkg::OP_DD:   begin a_op = 36'(d);    b_op = 36'(d); end
      stma_pkg::OP_D3:   begin a_op = 36'(t1);   b_op = 36'(d); end
      stma_pkg::OP_H:    begin a_op = 36'(d3);   b_op = 36'(tn); shamt = 7'd17; end
      stma_pkg::OP_T7:   begin
        a_op = 36'(tn7); b_op = 36'(stma_pkg::RECIP10); shamt = 7'd35;
      end
      stma_pkg::OP_S:    begin a_op = 36'({xmag, 4'b0}); b_op = 36'(g); end
      stma_pkg::OP_A2:   begin a_op = 36'(a);    b_op = 36'(a); shamt = 7'd27; end
      stma_pkg::OP_DENS: begin
        a_op = 36'(t1); b_op = 36'(stma_pkg::GOLD_Q32); shamt = 7'd32;
      end
      stma_pkg::OP_U:    begin a_op = 36'(a); b_op = 36'({dens, 1'b0}); shamt = 7'd27; end
      stma_pkg::OP_V:    begin a_op = u; b_op = 36'(stma_pkg::LOG2E_Q16); end
      stma_pkg::OP_EI:   begin a_op = 36'(ediff); b_op = 36'(erem); shamt = 7'd23; end
      stma_pkg::OP_PH:   begin a_op = 36'(a); b_op = 36'(dens); shamt = 7'd27; end
      stma_pkg::OP_SI:   begin a_op = 36'(sdiff); b_op = 36'(srem); shamt = 7'd22; end
      stma_pkg::OP_H20:  begin
        a_op = 36'(sinv); b_op = 36'(stma_pkg::RECIP10); shamt = 7'd36;
      end
      stma_pkg::OP_F1:   begin a_op = mag1; b_op = 36'(tn); end
      stma_pkg::OP_F2:   begin a_op = mag2; b_op = 36'(t7); end
      stma_pkg::OP_MX:   begin a_op = mag3; b_op = 36'(c); end
      stma_pkg::OP_HG:   begin a_op = omag; b_op = 36'(h); end
      default:           begin a_op = '0; b_op = '0; end
    endcase
  end

  assign prod_sh = 36'(prod >> shamt);

  stma_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .a_op  (a_op),
    .b_op  (b_op),
    .prod  (prod),
    .done  (mul_done)
  );

  assign st.done = mul_done;
  assign st.byp  = bypass;
  assign st.half = dens > stma_pkg::HALF_Q;
  assign st.thr  = dens > stma_pkg::THR_Q;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive  <= '0;
      tone   <= stma_pkg::TONE_RST;
      mix    <= stma_pkg::UNITY;
      bypass <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        stma_pkg::REG_DRIVE:  drive  <= cfg_data;
        stma_pkg::REG_TONE:   tone   <= cfg_data;
        stma_pkg::REG_MIX:    mix    <= cfg_data;
        stma_pkg::REG_BYPASS: bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tone filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      st1 <= '0;
      st2 <= '0;
    end else if (cmd.wb && cmd.op == stma_pkg::OP_F1) begin
      st1 <= stma_pkg::sat_q(36'(st1) + (dif1[35] ? -prod_s : prod_s));
    end else if (cmd.wb && cmd.op == stma_pkg::OP_F2) begin
      st2 <= stma_pkg::sat_q(36'(st2) + (dif2[35] ? -prod_s : prod_s));
    end
  end

  logic [31:0] om, omc;
  logic        lim_hit;
  logic [23:0] osh;
  assign om      = o[31] ? 32'(-o) : 32'(o);
  assign lim_hit = om > stma_pkg::LIM_Q;
  assign omc     = lim_hit ? stma_pkg::LIM_Q : om;
  assign osh     = omc[27:4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x        <= sample_in;
      byp_item <= bypass;
    end
    if (cmd.emit) begin
      if (byp_item) begin
        sample_out <= x;
        limited    <= 1'b0;
      end else begin
        sample_out <= o[31] ? -$signed(osh) : $signed(osh);
        limited    <= lim_hit;
      end
    end
    if (cmd.wb) begin
      case (cmd.op)
        stma_pkg::OP_DD:   t1 <= prod_sh[31:0];
        stma_pkg::OP_D3:   d3 <= prod_sh[16:0];
        stma_pkg::OP_H:    hx <= prod_sh[16:0];
        stma_pkg::OP_T7:   t7 <= prod_sh[16:0];
        stma_pkg::OP_S:    a  <= (prod_sh > 36'h07FFFFFFF) ? 32'h7FFFFFFF : prod_sh[31:0];
        stma_pkg::OP_A2:   t1 <= prod_sh[31:0];
        stma_pkg::OP_DENS: begin
          dens <= prod_sh[31:0];
          w    <= s_val;
          ht   <= '0;
        end
        stma_pkg::OP_U:    u <= prod_sh;
        stma_pkg::OP_V:    v <= prod_sh;
        stma_pkg::OP_EI:   w <= spos ? $signed({4'b0, k}) : -$signed({4'b0, k});
        stma_pkg::OP_PH:   begin
          hneg <= sneg ^ ph[27];
          q    <= ({1'b0, ph[26:0]} > 28'(stma_pkg::HALF_Q)) ? ph_fold[26:0] : ph[26:0];
        end
        stma_pkg::OP_SI:   sinv <= sidx[4] ? {17'd65536, 11'b0} : sbase + prod_sh[27:0];
        stma_pkg::OP_H20:  ht <= hneg ? -$signed({9'b0, prod_sh[22:0]})
                                      : $signed({9'b0, prod_sh[22:0]});
        stma_pkg::OP_MX:   o <= stma_pkg::sat_q(36'(s_val) + (dif3[35] ? -prod_s : prod_s));
        stma_pkg::OP_HG:   o <= stma_pkg::sat_q(o[31] ? -prod_s : prod_s);
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/stma_chk.sv =====
// Port-level checks for the audio core, bound to the top level.
// Depends on stma_pkg and saturation_tone_mix_audio_core.
module stma_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [stma_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic limited
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(limited))
    else $error("output changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_limit_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && limited |->
      sample_out == stma_pkg::LIM_OUT || sample_out == -stma_pkg::LIM_OUT)
    else $error("limited flag without clamp value");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind saturation_tone_mix_audio_core stma_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .limited    (out_ch.limited)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for saturation_tone_mix_audio_core: a bit-exact predictor
// of the drive, saturation, tone and mix chain scores every output sample.
// Depends on stma_pkg and the channel interfaces in hdl/stma_if.sv.

class audio_scoreboard;
  typedef struct {
    logic signed [stma_pkg::SAMPLE_BITS-1:0] sample;
    logic limited;
  } audio_result_t;

  localparam longint QONE = 64'sd1 << 27;

  int unsigned exp2_q16[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
    48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
  int unsigned sin_q16[17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576,
    46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

  audio_result_t expected_q[$];
  longint lp_one, lp_two;
  logic [63:0] drive_reg, tone_reg, mix_reg;
  bit bypass_reg;
  int errors;

  function new();
    lp_one = 0;
    lp_two = 0;
    drive_reg = 0;
    tone_reg = 32768;
    mix_reg = 65536;
    bypass_reg = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [stma_pkg::IDX_BITS-1:0] idx,
                          logic [stma_pkg::CFG_BITS-1:0] val);
    case (idx)
      stma_pkg::REG_DRIVE:  drive_reg = 64'(val);
      stma_pkg::REG_TONE:   tone_reg = 64'(val);
      stma_pkg::REG_MIX:    mix_reg = 64'(val);
      stma_pkg::REG_BYPASS: bypass_reg = val[0];
      default: ;
    endcase
  endfunction

  function logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function longint signed_of(logic [63:0] m, bit neg);
    if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function longint qmul(longint a, logic [63:0] b, int sh);
    return signed_of(mulsh(magn(a), b, sh), a < 0);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483647) return -64'sd2147483647;
    return v;
  endfunction

  function logic [63:0] exp_neg(logic [63:0] u);
    logic [63:0] v, n, f, idx, rem, base, diff, val;
    v = mulsh(u, 64'd94548, 16);
    n = v >> 27;
    f = v & (QONE - 1);
    idx = f >> 23;
    rem = f & ((64'd1 << 23) - 1);
    if (n >= 64) return 0;
    base = 64'(exp2_q16[idx]) << 11;
    diff = 64'(exp2_q16[idx] - exp2_q16[idx + 1]) << 11;
    val = base - mulsh(diff, rem, 23);
    return val >> n;
  endfunction

  function logic [63:0] sine_half(logic [63:0] q);
    logic [63:0] idx, rem, base, diff;
    idx = q >> 22;
    rem = q & ((64'd1 << 22) - 1);
    if (idx >= 16) return 64'(sin_q16[16]) << 11;
    base = 64'(sin_q16[idx]) << 11;
    diff = 64'(sin_q16[idx + 1] - sin_q16[idx]) << 11;
    return base + mulsh(diff, rem, 22);
  endfunction

  // predicts the output of one accepted input sample and queues it
  function void note_sample(logic signed [stma_pkg::SAMPLE_BITS-1:0] smp);
    audio_result_t r;
    logic [63:0] d, tn, c, d3, g, h, t7, a, dens, e, ph, lim;
    longint x, s, w, k, hterm, p, o;
    bit neg;
    if (bypass_reg) begin
      r.sample = smp;
      r.limited = 0;
      expected_q.insert(expected_q.size(), r);
      return;
    end
    x = longint'(smp);
    d = drive_reg > 65536 ? 64'd65536 : drive_reg;
    tn = tone_reg > 65536 ? 64'd65536 : tone_reg;
    c = mix_reg > 65536 ? 64'd65536 : mix_reg;
    d3 = (((d * d) >> 16) * d) >> 16;
    g = 65536 + 4 * d3;
    h = 65536 + ((d3 * tn) >> 17);
    t7 = (tn * 7) / 10;
    s = clip32(qmul(signed_of(magn(x) << 4, x < 0), g, 16));
    a = magn(s);
    dens = mulsh(mulsh(a, a, 27), 64'h9E3779B9, 32);
    w = s;
    hterm = 0;
    if (dens > 64'(QONE / 2)) begin
      e = exp_neg(mulsh(a, 2 * dens, 27));
      k = QONE - longint'(e);
      w = s > 0 ? k : -k;
    end
    if (dens > 64'((3 * QONE) / 10)) begin
      ph = mulsh(a, dens, 27) & 64'(2 * QONE - 1);
      neg = s < 0;
      if (ph >= 64'(QONE)) begin
        neg = !neg;
        ph -= 64'(QONE);
      end
      if (ph > 64'(QONE / 2)) ph = 64'(QONE) - ph;
      hterm = signed_of(sine_half(ph) / 20, neg);
    end
    p = clip32(w + hterm);
    lp_one = clip32(lp_one + qmul(p - lp_one, tn, 16));
    lp_two = clip32(lp_two + qmul(lp_one - lp_two, t7, 16));
    o = clip32(s + qmul(lp_two - s, c, 16));
    o = clip32(qmul(o, h, 16));
    lim = 64'((19 * QONE) / 20);
    r.limited = 0;
    if (magn(o) > lim) begin
      o = signed_of(lim, o < 0);
      r.limited = 1;
    end
    r.sample = 24'(signed_of(magn(o) >> 4, o < 0));
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void check_result(logic signed [stma_pkg::SAMPLE_BITS-1:0] smp, logic lim);
    audio_result_t r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected output sample %0d limited %0b", $time, smp, lim);
      errors++;
      return;
    end
    r = expected_q.pop_front();
    if (smp !== r.sample) begin
      $display("%0t: sample_out expected %0d actual %0d", $time, r.sample, smp);
      errors++;
    end
    if (lim !== r.limited) begin
      $display("%0t: limited expected %0b actual %0b", $time, r.limited, lim);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst;
  stma_in_if in_ch();
  stma_out_if out_ch();
  stma_cfg_if cfg();

  audio_scoreboard sb;
  bit idle_gaps;
  bit hold_req;
  int quiet_cycles;

  saturation_tone_mix_audio_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    sb = new();
    rst <= 1;
    in_ch.valid <= 0;
    in_ch.sample_in <= '0;
    out_ch.ready <= 0;
    cfg.valid <= 0;
    cfg.index <= '0;
    cfg.data <= '0;
  end

  // watchdog on handshake progress
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample receiver: random stall per request, plus one long hold-off
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = idle_gaps ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        hold_req = 0;
        stall = 300;
      end
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(negedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.sample_out, out_ch.limited);
      @(posedge clk);
    end
  end

  // stops offering requests and waits until every result is back
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [stma_pkg::IDX_BITS-1:0] idx,
                           logic [stma_pkg::CFG_BITS-1:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_mode(logic [stma_pkg::CFG_BITS-1:0] drv,
                          logic [stma_pkg::CFG_BITS-1:0] tn,
                          logic [stma_pkg::CFG_BITS-1:0] mx, bit byp);
    drain();
    write_cfg(stma_pkg::REG_DRIVE, drv);
    write_cfg(stma_pkg::REG_TONE, tn);
    write_cfg(stma_pkg::REG_MIX, mx);
    write_cfg(stma_pkg::REG_BYPASS, {16'd0, byp});
    cfg.valid <= 0;
  endtask

  // valid stays high across back-to-back requests
  task automatic send_sample(logic signed [stma_pkg::SAMPLE_BITS-1:0] smp);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample_in <= smp;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    sb.note_sample(smp);
  endtask

  function automatic logic signed [stma_pkg::SAMPLE_BITS-1:0] rand_sample();
    logic signed [stma_pkg::SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = 24'($urandom);
      2: v = 24'(int'($urandom_range(0, 2097151)) - 1048576);
      3: v = $urandom_range(0, 1) ? 24'(8388607 - int'($urandom_range(0, 3000000)))
                                  : 24'(-8388608 + int'($urandom_range(0, 3000000)));
      default: v = 24'(int'($urandom_range(0, 511)) - 256);
    endcase
    return v;
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_sample(rand_sample());
  endtask

  initial begin
    logic signed [stma_pkg::SAMPLE_BITS-1:0] directed [0:17] = '{24'sd0, 24'sd8388607,
      -24'sd8388608, 24'sd1, -24'sd1, 24'sd4194304, -24'sd4194304, 24'sd5846000,
      -24'sd5846000, 24'sd7560000, -24'sd7560000, 24'sd7969177, 24'sd7969178,
      -24'sd7969178, 24'sd8000000, -24'sd8000000, 24'h555555, 24'hAAAAAA};
    idle_gaps = 1;
    hold_req = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults after reset, then drive at full and above range
    foreach (directed[i]) send_sample(directed[i]);
    set_mode(17'd65536, 17'd65536, 17'd65536, 0);
    foreach (directed[i]) send_sample(directed[i]);
    set_mode(17'd131071, 17'd0, 17'd0, 0);
    send_sample(24'sd8388607);
    send_sample(-24'sd8388608);
    set_mode(17'd0, 17'd0, 17'd65536, 1);
    send_sample(24'sd8388607);
    send_sample(-24'sd8388608);
    send_sample(24'sd0);

    set_mode(17'd40000, 17'd32768, 17'd65536, 0);
    hold_req = 1;
    random_burst(180);
    set_mode(17'd0, 17'd0, 17'd0, 0);
    idle_gaps = 0;
    random_burst(150);
    set_mode(17'd65536, 17'd65536, 17'd65536, 0);
    idle_gaps = 1;
    random_burst(80);
    drain();
    random_burst(80);
    set_mode(17'd131071, 17'd131071, 17'd131071, 0);
    random_burst(150);
    set_mode(17'd20000, 17'd5000, 17'd30000, 1);
    random_burst(120);
    set_mode(17'd20000, 17'd5000, 17'd30000, 0);
    random_burst(150);
    repeat (8) begin
      set_mode(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
               17'($urandom_range(0, 131071)), $urandom_range(0, 7) == 0);
      idle_gaps = $urandom_range(0, 3) != 0;
      random_burst(125);
    end
    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
